// ===== design/disk_stamp_rasterizer_macros.svh =====
// Assertion helpers used by the checker of the disk stamp rasterizer.
`ifndef DISK_STAMP_RASTERIZER_MACROS_SVH
`define DISK_STAMP_RASTERIZER_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define DSR_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define DSR_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/dsr_pkg.sv =====
package dsr_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 4;

  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int YW          = $clog2(MAX_HEIGHT);
  localparam int AW          = XW + YW;
  localparam int RAM_DEPTH   = 1 << AW;
  localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;

  // fixed field widths
  localparam int REQ_W = 2;
  localparam int CX_W  = 13;
  localparam int CY_W  = 12;
  localparam int R_W   = 9;
  localparam int COL_W = 32;
  localparam int PX_W  = 9;
  localparam int PY_W  = 8;
  localparam int CW_W  = 10;
  localparam int CH_W  = 9;
  localparam int CNT_W = 18;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = CW_W;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CW_W-1:0] CW_RESET = CW_W'(320);
  localparam logic [CH_W-1:0] CH_RESET = CH_W'(200);

  localparam logic [REQ_W-1:0] REQ_STAMP = REQ_W'(0);
  localparam logic [REQ_W-1:0] REQ_CLEAR = REQ_W'(1);
  localparam logic [REQ_W-1:0] REQ_READ  = REQ_W'(2);

  localparam int ONE  = 1 << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  // bounding box arithmetic widths
  localparam int BX_W = CX_W + 2;
  localparam int BY_W = CY_W + 2;

  // distance test widths
  localparam int MXW   = (XW + FRAC_BITS > CX_W) ? XW + FRAC_BITS : CX_W;
  localparam int MYW   = (YW + FRAC_BITS > CY_W) ? YW + FRAC_BITS : CY_W;
  localparam int D_W   = ((MXW > MYW) ? MXW : MYW) + 2;
  localparam int SQ_W  = 2 * D_W - 1;
  localparam int SUM_W = SQ_W + 1;
  localparam int R2_W  = 2 * R_W;

  localparam logic [CNT_W-1:0] CLEAR_COUNT = CNT_W'(STORE_WORDS);
  localparam logic [COL_W-1:0] MASK_CLEAR  = {COL_W{1'b1}};
  localparam logic [COL_W-1:0] VIS_CLEAR   = {COL_W{1'b0}};
  localparam logic [23:0]      ERASE_RGB   = 24'hFFFFFF;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PW    = $clog2(CQ_DEPTH);
  localparam int CQC_W    = $clog2(CQ_DEPTH + 1);
  localparam int RQ_DEPTH = 2;
  localparam int RQ_PW    = $clog2(RQ_DEPTH);
  localparam int RQC_W    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_NOP,
    OP_STAMP,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    BS_INIT,
    BS_IDLE,
    BS_STAMP,
    BS_DRAIN,
    BS_CLEAR,
    BS_READ
  } bst_e;

  typedef struct packed {
    op_e              op;
    logic [XW-1:0]    x0;
    logic [XW-1:0]    x1;
    logic [YW-1:0]    y0;
    logic [YW-1:0]    y1;
    logic [CX_W-1:0]  cx;
    logic [CY_W-1:0]  cy;
    logic [R_W-1:0]   r;
    logic [COL_W-1:0] mask_col;
    logic [COL_W-1:0] vis_col;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0] mask_color;
    logic [COL_W-1:0] visual_color;
    logic [CNT_W-1:0] pixels_written;
  } res_t;

endpackage

// ===== design/dsr_ram.sv =====
module dsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/dsr_front.sv =====
module dsr_front import dsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 push_i,
  output logic                 full_o,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [CX_W-1:0]      center_x_i,
  input  logic [CY_W-1:0]      center_y_i,
  input  logic [R_W-1:0]       radius_i,
  input  logic [COL_W-1:0]     stamp_color_i,
  input  logic [PX_W-1:0]      pixel_x_i,
  input  logic [PY_W-1:0]      pixel_y_i,
  input  logic                 init_busy_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  logic                 cmd_pop_i
);

  logic [CW_W-1:0] canvas_w_q;
  logic [CH_W-1:0] canvas_h_q;

  cmd_t             cq_q [CQ_DEPTH];
  logic [CQ_PW-1:0] cq_wp_q, cq_rp_q;
  logic [CQC_W-1:0] cq_cnt_q;

  logic accept;
  cmd_t cmd_new;

  logic [BX_W-1:0] bw, xlo, xhi_raw, xhi;
  logic [BY_W-1:0] bh, ylo, yhi_raw, yhi;
  logic            x_ok, y_ok, rd_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CW_RESET;
      canvas_h_q <= CH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i;
        CFG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // clipped bounding box of the disk, in whole pixels
  always_comb begin
    bw = (BX_W'(canvas_w_q) > BX_W'(MAX_WIDTH)) ? BX_W'(MAX_WIDTH) : BX_W'(canvas_w_q);
    bh = (BY_W'(canvas_h_q) > BY_W'(MAX_HEIGHT)) ? BY_W'(MAX_HEIGHT) : BY_W'(canvas_h_q);

    xlo = (BX_W'(center_x_i) < BX_W'(radius_i)) ? '0 :
          ((BX_W'(center_x_i) - BX_W'(radius_i)) >> FRAC_BITS);
    ylo = (BY_W'(center_y_i) < BY_W'(radius_i)) ? '0 :
          ((BY_W'(center_y_i) - BY_W'(radius_i)) >> FRAC_BITS);

    xhi_raw = (BX_W'(center_x_i) + BX_W'(radius_i) + BX_W'(ONE - 1)) >> FRAC_BITS;
    yhi_raw = (BY_W'(center_y_i) + BY_W'(radius_i) + BY_W'(ONE - 1)) >> FRAC_BITS;

    xhi = (xhi_raw > bw - BX_W'(1)) ? bw - BX_W'(1) : xhi_raw;
    yhi = (yhi_raw > bh - BY_W'(1)) ? bh - BY_W'(1) : yhi_raw;

    x_ok  = (bw != '0) && (xlo <= xhi);
    y_ok  = (bh != '0) && (ylo <= yhi);
    rd_ok = (BX_W'(pixel_x_i) < BX_W'(MAX_WIDTH)) && (BY_W'(pixel_y_i) < BY_W'(MAX_HEIGHT));
  end

  always_comb begin
    cmd_new          = '0;
    cmd_new.cx       = center_x_i;
    cmd_new.cy       = center_y_i;
    cmd_new.r        = radius_i;
    cmd_new.mask_col = stamp_color_i;
    cmd_new.vis_col  = (stamp_color_i[31:8] == ERASE_RGB) ? VIS_CLEAR : stamp_color_i;
    cmd_new.x0       = xlo[XW-1:0];
    cmd_new.x1       = xhi[XW-1:0];
    cmd_new.y0       = ylo[YW-1:0];
    cmd_new.y1       = yhi[YW-1:0];
    unique case (req_type_i)
      REQ_STAMP: cmd_new.op = (x_ok && y_ok) ? OP_STAMP : OP_NOP;
      REQ_CLEAR: cmd_new.op = OP_CLEAR;
      REQ_READ: begin
        cmd_new.op = rd_ok ? OP_READ : OP_NOP;
        cmd_new.x0 = XW'(pixel_x_i);
        cmd_new.y0 = YW'(pixel_y_i);
      end
      default: cmd_new.op = OP_NOP;
    endcase
  end

  assign full_o      = (cq_cnt_q == CQC_W'(CQ_DEPTH)) || init_busy_i;
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = (cq_cnt_q != '0);
  assign cmd_o       = cq_q[cq_rp_q];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cq_q[cq_wp_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_wp_q  <= '0;
      cq_rp_q  <= '0;
      cq_cnt_q <= '0;
    end else begin
      if (accept) begin
        cq_wp_q <= (cq_wp_q == CQ_PW'(CQ_DEPTH - 1)) ? '0 : cq_wp_q + CQ_PW'(1);
      end
      if (cmd_pop_i) begin
        cq_rp_q <= (cq_rp_q == CQ_PW'(CQ_DEPTH - 1)) ? '0 : cq_rp_q + CQ_PW'(1);
      end
      cq_cnt_q <= cq_cnt_q + CQC_W'(accept) - CQC_W'(cmd_pop_i);
    end
  end

endmodule

// ===== design/dsr_back.sv =====
module dsr_back import dsr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic init_busy_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  bst_e state_q, state_d;
  cmd_t cur_q;
  logic [R2_W-1:0] r2_q;
  logic [XW-1:0]   gx_q;
  logic [YW-1:0]   gy_q;
  logic [AW-1:0]   clr_q;
  logic [CNT_W-1:0] cnt_q;

  // distance pipeline: offsets, then squares, then compare and write
  logic                  v1_q, v2_q, gen_v;
  logic signed [D_W-1:0] dx_q, dy_q;
  logic [AW-1:0]         a1_q, a2_q;
  logic [SQ_W-1:0]       dx2_q, dy2_q;
  logic signed [2*D_W-1:0] dx_sq, dy_sq;
  logic                  hit;

  logic             we, re;
  logic [AW-1:0]    waddr;
  logic [COL_W-1:0] wmask, wvis, rmask, rvis;
  logic             row_end, box_end;

  res_t             rq_q [RQ_DEPTH];
  logic [RQ_PW-1:0] rq_wp_q, rq_rp_q;
  logic [RQC_W-1:0] rq_cnt_q;
  logic             res_push, res_pop;
  res_t             res_d;

  assign row_end = (gx_q == cur_q.x1);
  assign box_end = row_end && (gy_q == cur_q.y1);
  assign hit     = v2_q && ((SUM_W'(dx2_q) + SUM_W'(dy2_q)) <= SUM_W'(r2_q));
  assign dx_sq   = dx_q * dx_q;
  assign dy_sq   = dy_q * dy_q;

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    gen_v     = 1'b0;
    res_push  = 1'b0;
    res_d     = '0;
    re        = 1'b0;
    we        = hit;
    waddr     = a2_q;
    wmask     = cur_q.mask_col;
    wvis      = cur_q.vis_col;
    unique case (state_q)
      BS_INIT: begin
        we    = 1'b1;
        waddr = clr_q;
        wmask = MASK_CLEAR;
        wvis  = VIS_CLEAR;
        if (&clr_q) begin
          state_d = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (cmd_valid_i && (rq_cnt_q != RQC_W'(RQ_DEPTH))) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_STAMP: state_d = BS_STAMP;
            OP_CLEAR: state_d = BS_CLEAR;
            OP_READ: begin
              re      = 1'b1;
              state_d = BS_READ;
            end
            OP_NOP: res_push = 1'b1;
            default: res_push = 1'b1;
          endcase
        end
      end
      BS_STAMP: begin
        gen_v = 1'b1;
        if (box_end) begin
          state_d = BS_DRAIN;
        end
      end
      BS_DRAIN: begin
        if (!v1_q && !v2_q) begin
          res_push             = 1'b1;
          res_d.pixels_written = cnt_q;
          state_d              = BS_IDLE;
        end
      end
      BS_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wmask = MASK_CLEAR;
        wvis  = VIS_CLEAR;
        if (&clr_q) begin
          res_push             = 1'b1;
          res_d.pixels_written = CLEAR_COUNT;
          state_d              = BS_IDLE;
        end
      end
      BS_READ: begin
        res_push           = 1'b1;
        res_d.mask_color   = rmask;
        res_d.visual_color = rvis;
        state_d            = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_INIT;
      clr_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= gen_v;
      v2_q    <= v1_q;
      if (state_q == BS_INIT || state_q == BS_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end else begin
        clr_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cur_q <= cmd_i;
      r2_q  <= R2_W'(cmd_i.r) * R2_W'(cmd_i.r);
      gx_q  <= cmd_i.x0;
      gy_q  <= cmd_i.y0;
      cnt_q <= '0;
    end else begin
      if (gen_v) begin
        if (row_end) begin
          gx_q <= cur_q.x0;
          gy_q <= gy_q + YW'(1);
        end else begin
          gx_q <= gx_q + XW'(1);
        end
      end
      if (hit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
    // pixel center minus disk center, both at FRAC_BITS fraction bits
    dx_q  <= D_W'({gx_q, {FRAC_BITS{1'b0}}}) + D_W'(HALF) - D_W'(cur_q.cx);
    dy_q  <= D_W'({gy_q, {FRAC_BITS{1'b0}}}) + D_W'(HALF) - D_W'(cur_q.cy);
    a1_q  <= {gy_q, gx_q};
    dx2_q <= dx_sq[SQ_W-1:0];
    dy2_q <= dy_sq[SQ_W-1:0];
    a2_q  <= a1_q;
  end

  dsr_ram #(.WIDTH(COL_W), .DEPTH(RAM_DEPTH)) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wmask),
    .re_i    (re),
    .raddr_i ({cmd_i.y0, cmd_i.x0}),
    .rdata_o (rmask)
  );

  dsr_ram #(.WIDTH(COL_W), .DEPTH(RAM_DEPTH)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wvis),
    .re_i    (re),
    .raddr_i ({cmd_i.y0, cmd_i.x0}),
    .rdata_o (rvis)
  );

  // result queue
  assign empty_o     = (rq_cnt_q == '0);
  assign res_pop     = pop_i && !empty_o;
  assign res_o       = rq_q[rq_rp_q];
  assign init_busy_o = (state_q == BS_INIT);

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rq_q[rq_wp_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wp_q  <= '0;
      rq_rp_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      if (res_push) begin
        rq_wp_q <= (rq_wp_q == RQ_PW'(RQ_DEPTH - 1)) ? '0 : rq_wp_q + RQ_PW'(1);
      end
      if (res_pop) begin
        rq_rp_q <= (rq_rp_q == RQ_PW'(RQ_DEPTH - 1)) ? '0 : rq_rp_q + RQ_PW'(1);
      end
      rq_cnt_q <= rq_cnt_q + RQC_W'(res_push) - RQC_W'(res_pop);
    end
  end

endmodule

// ===== design/disk_stamp_rasterizer.sv =====
// A stamp walks the clipped box, a clear writes all RAM_DEPTH (131072) words, a read uses a
// registered store read, other requests queue an empty result. Throughput: the back end
// walks the box one pixel per cycle and, with room in the result queue, takes the next
// request in the cycle after a result is queued; two more wait in the command queue.
// Reset: async active low; afterwards a pass clearing all 131072 words runs with full high.
module disk_stamp_rasterizer import dsr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 push,
  output logic                 full,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [CX_W-1:0]      center_x_i,
  input  logic [CY_W-1:0]      center_y_i,
  input  logic [R_W-1:0]       radius_i,
  input  logic [COL_W-1:0]     stamp_color_i,
  input  logic [PX_W-1:0]      pixel_x_i,
  input  logic [PY_W-1:0]      pixel_y_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [COL_W-1:0]     mask_color_o,
  output logic [COL_W-1:0]     visual_color_o,
  output logic [CNT_W-1:0]     pixels_written_o
);

  logic cmd_valid, cmd_pop, init_busy;
  cmd_t cmd;
  res_t res;

  dsr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .stamp_color_i (stamp_color_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .init_busy_i   (init_busy),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  dsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .init_busy_o (init_busy),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign mask_color_o     = res.mask_color;
  assign visual_color_o   = res.visual_color;
  assign pixels_written_o = res.pixels_written;

endmodule

// ===== design/dsr_checker.sv =====
`include "disk_stamp_rasterizer_macros.svh"

module dsr_checker import dsr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             push,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input logic [COL_W-1:0] mask_color_o,
  input logic [COL_W-1:0] visual_color_o,
  input logic [CNT_W-1:0] pixels_written_o
);

  `DSR_ASSERT_CLK(a_res_held, !empty && !pop |=> !empty, "waiting result dropped")
  `DSR_ASSERT_CLK(a_res_stable, !empty && !pop |=> $stable(mask_color_o) && $stable(visual_color_o) && $stable(pixels_written_o), "waiting result changed")
  `DSR_ASSERT_CLK(a_read_no_count, !empty && (mask_color_o != '0 || visual_color_o != '0) |-> pixels_written_o == '0, "read result carries a pixel count")
  `DSR_ASSERT_CLK(a_count_bound, !empty |-> pixels_written_o <= CLEAR_COUNT, "pixel count exceeds store size")
  `DSR_ASSERT_ANY(a_reset_state, !rst_ni |-> full && empty, "queues not closed during reset")

endmodule

bind disk_stamp_rasterizer dsr_checker u_dsr_checker (.*);
